// File: design/acpu_pkg.sv
// shared constants, codes and control word types for the accumulator cpu step block
package acpu_pkg;

  localparam int MEM_WORDS = 256;
  localparam int WORD_BITS = 16;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int OPC_BITS  = 12;
  localparam int UPC_BITS  = 3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [AW-1:0]        maddr_t;
  typedef logic [UPC_BITS-1:0]  upc_t;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_EXEC = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_MEM = 2'd0,
    MODE_IMM = 2'd1,
    MODE_IDX = 2'd2,
    MODE_REL = 2'd3
  } mode_e;

  typedef enum logic [OPC_BITS-1:0] {
    OP_MOVE = 12'd0,
    OP_ADD  = 12'd1,
    OP_SUB  = 12'd2,
    OP_BRA  = 12'd3,
    OP_CMP  = 12'd4,
    OP_BEQ  = 12'd5,
    OP_BNE  = 12'd6,
    OP_EXG  = 12'd7,
    OP_OR   = 12'd8,
    OP_XOR  = 12'd9,
    OP_AND  = 12'd10,
    OP_STOP = 12'd15
  } opcode_e;

  typedef enum logic [1:0] {
    MEM_IDLE = 2'd0,
    MEM_RD   = 2'd1,
    MEM_WR   = 2'd2,
    MEM_WB   = 2'd3
  } mem_op_e;

  typedef enum logic [1:0] {
    AS_REQ = 2'd0,
    AS_PC  = 2'd1,
    AS_SRC = 2'd2,
    AS_WB  = 2'd3
  } addr_sel_e;

  typedef struct packed {
    mem_op_e   mem_op;
    addr_sel_e addr_sel;
    logic      pc_inc;
    logic      ld_opword;
    logic      ld_operand;
    logic      exec;
    logic      cap_rdata;
    logic      jmp_halt;
    upc_t      target;
    logic      last;
  } ucode_t;

  localparam upc_t UA_LOAD  = 3'd0;
  localparam upc_t UA_READ0 = 3'd1;
  localparam upc_t UA_READ1 = 3'd2;
  localparam upc_t UA_EX0   = 3'd3;
  localparam upc_t UA_EX1   = 3'd4;
  localparam upc_t UA_EX2   = 3'd5;
  localparam upc_t UA_EX3   = 3'd6;
  localparam upc_t UA_NOP   = 3'd7;

endpackage

// File: design/accumulator_cpu_step.sv
// accumulator cpu step: microcoded sequencer, one-port word memory and register datapath
// every accepted request ends with a result strobe; an execute while halted ends without state change
// otherwise execute runs four microcode steps on the one-port memory: opcode fetch, operand fetch,
// source read, then execute with conditional write-back; busy drops in the strobe cycle,
// so the next item is taken there; a new item waits until the last one is through
// reset clears d0, a0, pc, flag, hold and halt; memory content stays undefined until written
module accumulator_cpu_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [acpu_pkg::AW-1:0]       addr_i,
  input  logic [acpu_pkg::WORD_BITS-1:0] wdata_i,
  output logic                          done_o,
  output logic [acpu_pkg::WORD_BITS-1:0] rdata_o,
  output logic [acpu_pkg::WORD_BITS-1:0] d0_value_o,
  output logic [acpu_pkg::WORD_BITS-1:0] a0_value_o,
  output logic [acpu_pkg::AW-1:0]       pc_value_o,
  output logic                          zero_flag_o,
  output logic                          halted_o
);
  import acpu_pkg::*;

  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t u;
    u = '{mem_op: MEM_IDLE, addr_sel: AS_REQ, pc_inc: 1'b0, ld_opword: 1'b0,
          ld_operand: 1'b0, exec: 1'b0, cap_rdata: 1'b0, jmp_halt: 1'b0,
          target: UA_NOP, last: 1'b0};
    unique case (a)
      UA_LOAD: begin
        u.mem_op = MEM_WR;
        u.last   = 1'b1;
      end
      UA_READ0: begin
        u.mem_op = MEM_RD;
      end
      UA_READ1: begin
        u.cap_rdata = 1'b1;
        u.last      = 1'b1;
      end
      UA_EX0: begin
        u.jmp_halt = 1'b1;
        u.target   = UA_NOP;
        u.mem_op   = MEM_RD;
        u.addr_sel = AS_PC;
        u.pc_inc   = 1'b1;
      end
      UA_EX1: begin
        u.ld_opword = 1'b1;
        u.mem_op    = MEM_RD;
        u.addr_sel  = AS_PC;
        u.pc_inc    = 1'b1;
      end
      UA_EX2: begin
        u.ld_operand = 1'b1;
        u.mem_op     = MEM_RD;
        u.addr_sel   = AS_SRC;
      end
      UA_EX3: begin
        u.exec     = 1'b1;
        u.mem_op   = MEM_WB;
        u.addr_sel = AS_WB;
        u.last     = 1'b1;
      end
      default: begin
        u.last = 1'b1;
      end
    endcase
    return u;
  endfunction

  logic   active_q, done_q;
  upc_t   upc_q;
  word_t  d0_q, a0_q, hold_q;
  maddr_t pc_q;
  logic   zero_q, halt_q;
  word_t  opword_q, operand_q, mem_rdata_q, rdata_q;
  maddr_t addr_q;
  word_t  wdata_q;
  word_t  mem_q [MEM_WORDS];

  ucode_t  ctl;
  logic    accept, take_jmp, act;
  upc_t    entry;
  mode_e   mode;
  logic    dir;
  opcode_e op;
  word_t   src, res, d0_d, a0_d, hold_d;
  maddr_t  pc_d;
  logic    zero_d, halt_d, take_br;
  maddr_t  mem_addr;
  word_t   mem_wdata;
  logic    mem_we, mem_re;

  assign accept   = start && !active_q;
  assign ctl      = ucode_rom(upc_q);
  assign take_jmp = active_q && ctl.jmp_halt && halt_q;
  assign act      = active_q && !take_jmp;

  assign mode = mode_e'(opword_q[1:0]);
  assign dir  = opword_q[2];
  assign op   = opcode_e'(opword_q[WORD_BITS-1:4]);

  always_comb begin
    unique case (req_e'(req_type_i))
      REQ_LOAD: entry = UA_LOAD;
      REQ_EXEC: entry = UA_EX0;
      REQ_READ: entry = UA_READ0;
      default:  entry = UA_NOP;
    endcase
  end

  always_comb begin
    src     = (mode == MODE_IMM) ? operand_q : mem_rdata_q;
    d0_d    = d0_q;
    a0_d    = a0_q;
    hold_d  = hold_q;
    pc_d    = pc_q;
    zero_d  = zero_q;
    halt_d  = halt_q;
    take_br = 1'b0;
    unique case (op)
      OP_ADD:  res = d0_q + src;
      OP_SUB:  res = d0_q - src;
      OP_AND:  res = d0_q & src;
      OP_OR:   res = d0_q | src;
      default: res = d0_q ^ src;
    endcase
    unique case (op)
      OP_MOVE: begin
        if (dir) begin
          d0_d   = src;
          zero_d = (src == '0);
        end else begin
          hold_d = d0_q;
          zero_d = (d0_q == '0);
        end
      end
      OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
        if (dir) d0_d = res;
        else hold_d = res;
        zero_d = (res == '0);
      end
      OP_CMP:  zero_d = (res == '0);
      OP_BRA:  take_br = 1'b1;
      OP_BEQ:  take_br = zero_q;
      OP_BNE:  take_br = !zero_q;
      OP_EXG: begin
        d0_d = a0_q;
        a0_d = d0_q;
      end
      OP_STOP: halt_d = 1'b1;
      default: ;
    endcase
    if (take_br) begin
      if (mode == MODE_MEM) pc_d = operand_q[AW-1:0];
      else if (mode == MODE_IMM) pc_d = pc_q + operand_q[AW-1:0];
    end
  end

  // memory address and write selection
  always_comb begin
    unique case (ctl.addr_sel)
      AS_REQ: mem_addr = addr_q;
      AS_PC:  mem_addr = pc_q;
      AS_SRC: begin
        unique case (mode)
          MODE_IDX: mem_addr = a0_q[AW-1:0] + mem_rdata_q[AW-1:0];
          MODE_REL: mem_addr = pc_q + mem_rdata_q[AW-1:0];
          default:  mem_addr = mem_rdata_q[AW-1:0];
        endcase
      end
      default: begin
        unique case (mode)
          MODE_IDX: mem_addr = a0_d[AW-1:0] + operand_q[AW-1:0];
          MODE_REL: mem_addr = pc_d + operand_q[AW-1:0];
          default:  mem_addr = operand_q[AW-1:0];
        endcase
      end
    endcase
    mem_wdata = (ctl.mem_op == MEM_WR) ? wdata_q : hold_d;
    mem_we    = act && ((ctl.mem_op == MEM_WR) ||
                ((ctl.mem_op == MEM_WB) && !dir && (mode != MODE_IMM)));
    mem_re    = act && (ctl.mem_op == MEM_RD);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      mem_rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q  <= addr_i;
      wdata_q <= wdata_i;
    end
    if (act && ctl.ld_opword) opword_q <= mem_rdata_q;
    if (act && ctl.ld_operand) operand_q <= mem_rdata_q;
    if (active_q && ctl.last) rdata_q <= (act && ctl.cap_rdata) ? mem_rdata_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      upc_q    <= UA_NOP;
      d0_q     <= '0;
      a0_q     <= '0;
      hold_q   <= '0;
      pc_q     <= '0;
      zero_q   <= 1'b0;
      halt_q   <= 1'b0;
    end else begin
      done_q <= active_q && ctl.last && !take_jmp;
      if (accept) begin
        active_q <= 1'b1;
        upc_q    <= entry;
      end else if (active_q) begin
        if (take_jmp) begin
          upc_q <= ctl.target;
        end else if (ctl.last) begin
          active_q <= 1'b0;
        end else begin
          upc_q <= upc_q + 1'b1;
        end
      end
      if (act && ctl.pc_inc) pc_q <= pc_q + 1'b1;
      if (act && ctl.exec) begin
        d0_q   <= d0_d;
        a0_q   <= a0_d;
        hold_q <= hold_d;
        pc_q   <= pc_d;
        zero_q <= zero_d;
        halt_q <= halt_d;
      end
    end
  end

  assign busy        = active_q;
  assign done_o      = done_q;
  assign rdata_o     = rdata_q;
  assign d0_value_o  = d0_q;
  assign a0_value_o  = a0_q;
  assign pc_value_o  = pc_q;
  assign zero_flag_o = zero_q;
  assign halted_o    = halt_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while an item is still in work");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted item did not start the sequencer");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_o |=> halted_o)
    else $error("halt cleared without reset");

  a_halt_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_o) |-> done_o)
    else $error("halt set outside an execute result");

  a_regs_quiet_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !$past(busy)) |-> ($stable(pc_value_o) && $stable(d0_value_o)))
    else $error("registers moved while idle");

endmodule

// File: tb/accumulator_cpu_step_tb.sv
// testbench for accumulator_cpu_step: directed and random requests checked against a register model
module accumulator_cpu_step_tb;
  import acpu_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 850;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    req_e   req;
    maddr_t addr;
    word_t  wdata;
  } cpu_req_t;

  typedef struct packed {
    word_t  rdata;
    word_t  d0;
    word_t  a0;
    maddr_t pc;
    logic   zf;
    logic   halt;
  } cpu_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type_i = '0;
  maddr_t addr_i = '0;
  word_t wdata_i = '0;
  logic done_o;
  word_t rdata_o;
  word_t d0_value_o;
  word_t a0_value_o;
  maddr_t pc_value_o;
  logic zero_flag_o;
  logic halted_o;

  // register model state
  word_t mem_img [MEM_WORDS];
  bit mem_set [MEM_WORDS];
  word_t d0_q, a0_q, hold_q;
  maddr_t pc_q;
  logic zf_q, halt_q;

  cpu_req_t pending_reqs [$];
  cpu_res_t reg_snapshots [$];
  cpu_req_t in_flight;
  cpu_res_t want;
  int n_issued, n_accepted, n_items, n_errors, n_cycles;
  int gap_left, burst_left = 1;

  opcode_e op_list [11] = '{OP_MOVE, OP_ADD, OP_SUB, OP_BRA, OP_CMP, OP_BEQ, OP_BNE,
                            OP_EXG, OP_OR, OP_XOR, OP_AND};

  accumulator_cpu_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .addr_i      (addr_i),
    .wdata_i     (wdata_i),
    .done_o      (done_o),
    .rdata_o     (rdata_o),
    .d0_value_o  (d0_value_o),
    .a0_value_o  (a0_value_o),
    .pc_value_o  (pc_value_o),
    .zero_flag_o (zero_flag_o),
    .halted_o    (halted_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic maddr_t eff_addr(mode_e md, word_t opnd, word_t a0, maddr_t pc_now);
    case (md)
      MODE_IDX: return a0[AW-1:0] + opnd[AW-1:0];
      MODE_REL: return pc_now + opnd[AW-1:0];
      default:  return opnd[AW-1:0];
    endcase
  endfunction

  function automatic cpu_res_t cpu_step(cpu_req_t rq);
    cpu_res_t r;
    word_t opw, opnd, src, alu;
    maddr_t ea;
    mode_e md;
    logic dir;
    logic [OPC_BITS-1:0] opc;
    r.rdata = '0;
    if (rq.req == REQ_LOAD) begin
      mem_img[rq.addr] = rq.wdata;
      mem_set[rq.addr] = 1'b1;
    end else if (rq.req == REQ_READ) begin
      r.rdata = mem_img[rq.addr];
    end else if (rq.req == REQ_EXEC && !halt_q) begin
      opw = mem_img[pc_q];
      pc_q = pc_q + 8'd1;
      opnd = mem_img[pc_q];
      pc_q = pc_q + 8'd1;
      md = mode_e'(opw[1:0]);
      dir = opw[2];
      opc = opw[15:4];
      ea = eff_addr(md, opnd, a0_q, pc_q);
      src = (md == MODE_IMM) ? opnd : mem_img[ea];
      case (opc)
        OP_MOVE: begin
          if (dir) d0_q = src;
          else hold_q = d0_q;
          zf_q = (d0_q == '0);
        end
        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
          case (opc)
            OP_ADD:  alu = d0_q + src;
            OP_SUB:  alu = d0_q - src;
            OP_AND:  alu = d0_q & src;
            OP_OR:   alu = d0_q | src;
            default: alu = d0_q ^ src;
          endcase
          if (dir) d0_q = alu;
          else hold_q = alu;
          zf_q = (alu == '0);
        end
        OP_CMP: begin
          alu = d0_q - src;
          zf_q = (alu == '0);
        end
        OP_BRA, OP_BEQ, OP_BNE: begin
          if (opc == OP_BRA || (opc == OP_BEQ && zf_q) || (opc == OP_BNE && !zf_q)) begin
            if (md == MODE_MEM) pc_q = opnd[AW-1:0];
            else if (md == MODE_IMM) pc_q = pc_q + opnd[AW-1:0];
          end
        end
        OP_EXG: begin
          alu = d0_q;
          d0_q = a0_q;
          a0_q = alu;
        end
        OP_STOP: halt_q = 1'b1;
        default: ;
      endcase
      // write-back uses a0 and pc after execution
      if (!dir && md != MODE_IMM) begin
        ea = eff_addr(md, opnd, a0_q, pc_q);
        mem_img[ea] = hold_q;
        mem_set[ea] = 1'b1;
      end
    end
    r.d0 = d0_q;
    r.a0 = a0_q;
    r.pc = pc_q;
    r.zf = zf_q;
    r.halt = halt_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp_val);
    if (n_errors < PRINT_LIMIT)
      $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, exp_val, n_cycles);
    n_errors++;
  endtask

  // driver: bursts of items with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        reg_snapshots.push_back(cpu_step(in_flight));
        n_accepted++;
      end
      if (start && busy) begin
        // hold the item until taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_flight = pending_reqs.pop_front();
        req_type_i <= in_flight.req;
        addr_i <= in_flight.addr;
        wdata_i <= in_flight.wdata;
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
          gap_left = $urandom_range(1, 9);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (reg_snapshots.size() == 0) begin
        report_mismatch("unexpected result", rdata_o, '0);
      end else begin
        want = reg_snapshots.pop_front();
        if (rdata_o !== want.rdata) report_mismatch("rdata", rdata_o, want.rdata);
        if (d0_value_o !== want.d0) report_mismatch("d0_value", d0_value_o, want.d0);
        if (a0_value_o !== want.a0) report_mismatch("a0_value", a0_value_o, want.a0);
        if (pc_value_o !== want.pc)
          report_mismatch("pc_value", 16'(pc_value_o), 16'(want.pc));
        if (zero_flag_o !== want.zf)
          report_mismatch("zero_flag", 16'(zero_flag_o), 16'(want.zf));
        if (halted_o !== want.halt)
          report_mismatch("halted", 16'(halted_o), 16'(want.halt));
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // queue one item and wait until it has been taken, so the model state is current
  task automatic push_item(req_e rq, maddr_t a, word_t w);
    pending_reqs.push_back('{rq, a, w});
    n_issued++;
    if (rq != REQ_NONE) n_items++;
    while (n_accepted != n_issued) @(negedge clk_i);
  endtask

  function automatic word_t insn(opcode_e op, bit dir, mode_e md);
    return {op, 1'b0, dir, md};
  endfunction

  function automatic word_t rand_opword(bit stop_ok);
    word_t w;
    do begin
      case ($urandom_range(0, 19))
        0, 1:    w = word_t'($urandom);
        2:       w = {12'($urandom_range(11, 14)), 4'($urandom)};
        default: w = {op_list[$urandom_range(0, 10)], 4'($urandom)};
      endcase
    end while (!stop_ok && w[15:4] == OP_STOP);
    return w;
  endfunction

  function automatic word_t rand_operand();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return word_t'($urandom_range(0, 7));
      3:       return d0_q;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic maddr_t any_written_addr();
    maddr_t a;
    a = maddr_t'($urandom);
    for (int k = 0; k < MEM_WORDS && !mem_set[a]; k++) a = a + 8'd1;
    return a;
  endfunction

  // fill any unwritten word the instruction will read and replace a stop opword unless stop_ok, then execute
  task automatic exec_item(bit stop_ok);
    maddr_t nxt, ea;
    if (!halt_q) begin
      nxt = pc_q + 8'd1;
      if (!mem_set[pc_q] || (!stop_ok && mem_img[pc_q][15:4] == OP_STOP))
        push_item(REQ_LOAD, pc_q, rand_opword(stop_ok));
      if (!mem_set[nxt]) push_item(REQ_LOAD, nxt, rand_operand());
      ea = eff_addr(mode_e'(mem_img[pc_q][1:0]), mem_img[nxt], a0_q, nxt + 8'd1);
      if (mem_img[pc_q][1:0] != MODE_IMM && !mem_set[ea])
        push_item(REQ_LOAD, ea, word_t'($urandom));
    end
    push_item(REQ_EXEC, maddr_t'($urandom), word_t'($urandom));
  endtask

  task automatic gen_program();
    maddr_t at;
    int n;
    at = pc_q;
    n = $urandom_range(2, 8);
    for (int i = 0; i < n; i++) begin
      push_item(REQ_LOAD, at, rand_opword(1'b0));
      push_item(REQ_LOAD, at + 8'd1, rand_operand());
      at = at + 8'd2;
    end
    repeat ($urandom_range(0, 3)) push_item(REQ_LOAD, maddr_t'($urandom), word_t'($urandom));
    repeat (n) exec_item(1'b0);
  endtask

  initial begin
    word_t boot [12];
    int sel;
    boot = '{insn(OP_MOVE, 1'b1, MODE_IMM), 16'hFFFF,
             insn(OP_EXG,  1'b1, MODE_IMM), 16'h0000,
             insn(OP_MOVE, 1'b1, MODE_IMM), 16'h8000,
             insn(OP_ADD,  1'b0, MODE_IDX), 16'h00F1,
             insn(OP_BEQ,  1'b1, MODE_IMM), 16'h0002,
             insn(OP_CMP,  1'b0, MODE_REL), 16'h00F1};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // wrap of an indexed address, zero result with write-back, taken relative jump
    // over a compare
    for (int i = 0; i < 12; i++) push_item(REQ_LOAD, maddr_t'(i), boot[i]);
    push_item(REQ_LOAD, 8'hF0, 16'h8000);
    push_item(REQ_LOAD, 8'hFF, 16'hFFFF);
    repeat (6) exec_item(1'b0);
    push_item(REQ_READ, 8'hF0, 16'hFFFF);
    push_item(REQ_READ, 8'hFF, 16'h0000);
    push_item(REQ_NONE, 8'hFF, 16'hFFFF);

    while (n_items < ITEM_TARGET) begin
      sel = $urandom_range(0, 19);
      if (sel < 11) gen_program();
      else if (sel < 15) repeat ($urandom_range(1, 6)) exec_item(1'b0);
      else if (sel < 17) push_item(REQ_LOAD, maddr_t'($urandom), word_t'($urandom));
      else if (sel < 19) push_item(REQ_READ, any_written_addr(), word_t'($urandom));
      else push_item(REQ_NONE, maddr_t'($urandom), word_t'($urandom));
    end

    // stop, then execute while halted
    push_item(REQ_LOAD, pc_q, insn(OP_STOP, 1'($urandom), mode_e'($urandom_range(0, 3))));
    exec_item(1'b1);
    repeat (3) exec_item(1'b1);
    push_item(REQ_READ, any_written_addr(), 16'h0000);
    push_item(REQ_NONE, 8'h00, 16'h0000);

    while (reg_snapshots.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: accumulator_cpu_step.f
design/acpu_pkg.sv
design/accumulator_cpu_step.sv
tb/accumulator_cpu_step_tb.sv
